// ===== src/ansi_cursor_sequence_generator_top_macros.svh =====
// Assertion macros for the checker file of the ANSI cursor sequence generator.
// Depends on nothing; included by acsg_checker.sv, which holds the concurrent assertions.
`ifndef ANSI_CURSOR_SEQUENCE_GENERATOR_TOP_MACROS_SVH
`define ANSI_CURSOR_SEQUENCE_GENERATOR_TOP_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define ACSG_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define ACSG_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== src/acsg_pkg.sv =====
// Package of the ANSI cursor sequence generator: widths, action codes, characters,
// the microcode format and program, and the decimal helper functions. No dependencies.
package acsg_pkg;

	// Field widths and operand digit settings.
	localparam int ACT_W          = 3;
	localparam int OP_W           = 16;
	localparam int BYTE_W         = 8;
	localparam int OPERAND_DIGITS = 5;
	// A 16-bit operand never has more than five decimal digits.
	localparam int NUM_POS        = (OPERAND_DIGITS < 5) ? OPERAND_DIGITS : 5;
	localparam int POS_W          = (NUM_POS > 1) ? $clog2(NUM_POS) : 1;
	localparam int PROD_W         = OP_W + 1;
	localparam int DIG_W          = 4;
	localparam int PC_W           = 5;

	// Action codes.
	localparam logic [ACT_W-1:0] ACT_SAVE       = 3'd0;
	localparam logic [ACT_W-1:0] ACT_RESTORE    = 3'd1;
	localparam logic [ACT_W-1:0] ACT_SET_POS    = 3'd2;
	localparam logic [ACT_W-1:0] ACT_ERASE_LEFT = 3'd3;
	localparam logic [ACT_W-1:0] ACT_CLS        = 3'd4;
	localparam logic [ACT_W-1:0] ACT_BACK       = 3'd5;
	localparam logic [ACT_W-1:0] ACT_INSERT     = 3'd6;

	// Characters of the escape sequences.
	localparam logic [BYTE_W-1:0] CH_NUL   = 8'h00;
	localparam logic [BYTE_W-1:0] CH_ESC   = 8'h1B;
	localparam logic [BYTE_W-1:0] CH_ZERO  = 8'h30;
	localparam logic [BYTE_W-1:0] CH_TWO   = 8'h32;
	localparam logic [BYTE_W-1:0] CH_SEVEN = 8'h37;
	localparam logic [BYTE_W-1:0] CH_EIGHT = 8'h38;
	localparam logic [BYTE_W-1:0] CH_SEMI  = 8'h3B;
	localparam logic [BYTE_W-1:0] CH_AT    = 8'h40;
	localparam logic [BYTE_W-1:0] CH_D     = 8'h44;
	localparam logic [BYTE_W-1:0] CH_H     = 8'h48;
	localparam logic [BYTE_W-1:0] CH_J     = 8'h4A;
	localparam logic [BYTE_W-1:0] CH_X     = 8'h58;
	localparam logic [BYTE_W-1:0] CH_LBRK  = 8'h5B;

	// Microcode step kinds.
	localparam logic [1:0] K_CONST = 2'd0;
	localparam logic [1:0] K_DIGIT = 2'd1;
	localparam logic [1:0] K_FINAL = 2'd2;

	// Operand load selects.
	localparam logic [1:0] LD_NONE = 2'd0;
	localparam logic [1:0] LD_OP1  = 2'd1;
	localparam logic [1:0] LD_OP2  = 2'd2;

	// Program entry points.
	localparam logic [PC_W-1:0] ENT_SAVE    = 5'd0;
	localparam logic [PC_W-1:0] ENT_RESTORE = 5'd2;
	localparam logic [PC_W-1:0] ENT_SET_POS = 5'd4;
	localparam logic [PC_W-1:0] ENT_CSI_N   = 5'd10;
	localparam logic [PC_W-1:0] ENT_CLS     = 5'd14;
	localparam logic [PC_W-1:0] ENT_BAD     = 5'd18;

	// One control word of the sequencer program.
	typedef struct packed {
		logic [1:0]        kind;
		logic [BYTE_W-1:0] chr;
		logic              last;
		logic              bad;
		logic [1:0]        load;
	} uword_t;

	// Control from the sequencer side to the digit unit.
	typedef struct packed {
		logic       step;
		logic [1:0] load;
		logic       digit;
	} dig_ctrl_t;

	// Status from the digit unit.
	typedef struct packed {
		logic [BYTE_W-1:0] chr;
		logic              emit;
		logic              last_pos;
	} dig_stat_t;

	// Power of ten, for elaboration-time constants and constant-indexed tables.
	function automatic longint unsigned pow10(input int k);
		longint unsigned r;
		r = 1;
		for (int i = 0; i < k; i++) begin
			r = r * 10;
		end
		return r;
	endfunction

	localparam longint unsigned OP_LIMIT = pow10(OPERAND_DIGITS) - 1;

	// Clamp an operand to the largest value with OPERAND_DIGITS digits.
	function automatic logic [OP_W-1:0] sat_op(input logic [OP_W-1:0] v);
		logic [OP_W-1:0] r;
		r = v;
		if (64'(v) > OP_LIMIT) begin
			r = OP_LIMIT[OP_W-1:0];
		end
		return r;
	endfunction

	// m times the place value of digit position pos.
	function automatic logic [PROD_W-1:0] pos_mult(input logic [POS_W-1:0] pos, input int m);
		logic [PROD_W-1:0] r;
		r = '0;
		for (int k = 0; k < NUM_POS; k++) begin
			if (pos == POS_W'(k)) begin
				r = PROD_W'(longint'(m) * pow10(k));
			end
		end
		return r;
	endfunction

	// Entry point of the program for an action.
	function automatic logic [PC_W-1:0] entry_of(input logic [ACT_W-1:0] act);
		logic [PC_W-1:0] r;
		case (act)
			ACT_SAVE:       r = ENT_SAVE;
			ACT_RESTORE:    r = ENT_RESTORE;
			ACT_SET_POS:    r = ENT_SET_POS;
			ACT_ERASE_LEFT: r = ENT_CSI_N;
			ACT_CLS:        r = ENT_CLS;
			ACT_BACK:       r = ENT_CSI_N;
			ACT_INSERT:     r = ENT_CSI_N;
			default:        r = ENT_BAD;
		endcase
		return r;
	endfunction

	function automatic uword_t mk(input logic [1:0] kind, input logic [BYTE_W-1:0] chr,
		input logic last, input logic bad, input logic [1:0] load);
		uword_t w;
		w.kind = kind;
		w.chr  = chr;
		w.last = last;
		w.bad  = bad;
		w.load = load;
		return w;
	endfunction

	// Sequencer program. Digit steps repeat until the lowest position is done.
	function automatic uword_t urom(input logic [PC_W-1:0] pc);
		uword_t w;
		case (pc)
			// Save cursor: ESC 7.
			5'd0:    w = mk(K_CONST, CH_ESC, 1'b0, 1'b0, LD_NONE);
			5'd1:    w = mk(K_CONST, CH_SEVEN, 1'b1, 1'b0, LD_NONE);
			// Restore cursor: ESC 8.
			5'd2:    w = mk(K_CONST, CH_ESC, 1'b0, 1'b0, LD_NONE);
			5'd3:    w = mk(K_CONST, CH_EIGHT, 1'b1, 1'b0, LD_NONE);
			// Set position: ESC [ row ; col H.
			5'd4:    w = mk(K_CONST, CH_ESC, 1'b0, 1'b0, LD_NONE);
			5'd5:    w = mk(K_CONST, CH_LBRK, 1'b0, 1'b0, LD_OP1);
			5'd6:    w = mk(K_DIGIT, CH_NUL, 1'b0, 1'b0, LD_NONE);
			5'd7:    w = mk(K_CONST, CH_SEMI, 1'b0, 1'b0, LD_OP2);
			5'd8:    w = mk(K_DIGIT, CH_NUL, 1'b0, 1'b0, LD_NONE);
			5'd9:    w = mk(K_CONST, CH_H, 1'b1, 1'b0, LD_NONE);
			// Erase left, back, insert: ESC [ n final.
			5'd10:   w = mk(K_CONST, CH_ESC, 1'b0, 1'b0, LD_NONE);
			5'd11:   w = mk(K_CONST, CH_LBRK, 1'b0, 1'b0, LD_OP1);
			5'd12:   w = mk(K_DIGIT, CH_NUL, 1'b0, 1'b0, LD_NONE);
			5'd13:   w = mk(K_FINAL, CH_NUL, 1'b1, 1'b0, LD_NONE);
			// Clear screen: ESC [ 2 J.
			5'd14:   w = mk(K_CONST, CH_ESC, 1'b0, 1'b0, LD_NONE);
			5'd15:   w = mk(K_CONST, CH_LBRK, 1'b0, 1'b0, LD_NONE);
			5'd16:   w = mk(K_CONST, CH_TWO, 1'b0, 1'b0, LD_NONE);
			5'd17:   w = mk(K_CONST, CH_J, 1'b1, 1'b0, LD_NONE);
			// Unknown action: one error result.
			default: w = mk(K_CONST, CH_NUL, 1'b1, 1'b1, LD_NONE);
		endcase
		return w;
	endfunction

endpackage

// ===== src/acsg_cmd_if.sv =====
// Command channel interface of the ANSI cursor sequence generator.
// Depends on acsg_pkg for the field widths.
interface acsg_cmd_if
	import acsg_pkg::*;
();
	logic             valid;
	logic             ready;
	logic [ACT_W-1:0] action;
	logic [OP_W-1:0]  first_operand;
	logic [OP_W-1:0]  second_operand;

	modport source(output valid, output action, output first_operand,
		output second_operand, input ready);
	modport sink(input valid, input action, input first_operand,
		input second_operand, output ready);
endinterface

// ===== src/acsg_byte_if.sv =====
// Byte channel interface of the ANSI cursor sequence generator.
// Depends on acsg_pkg for the field widths.
interface acsg_byte_if
	import acsg_pkg::*;
();
	logic              valid;
	logic              ready;
	logic [BYTE_W-1:0] out_byte;
	logic              last_byte;
	logic              bad_action;

	modport source(output valid, output out_byte, output last_byte,
		output bad_action, input ready);
	modport sink(input valid, input out_byte, input last_byte,
		input bad_action, output ready);
endinterface

// ===== src/acsg_digit_unit.sv =====
// Decimal digit unit: produces one ASCII digit of an operand per step, most significant first.
// Depends on acsg_pkg.
module acsg_digit_unit
	import acsg_pkg::*;
(
	input  logic            clk,
	input  logic            arst_n,
	input  dig_ctrl_t       ctl,
	input  logic [OP_W-1:0] op1,
	input  logic [OP_W-1:0] op2,
	output dig_stat_t       stat
);

	logic [OP_W-1:0]   work_q;
	logic [POS_W-1:0]  pos_q;
	logic              started_q;
	logic [PROD_W-1:0] thr [10];
	logic [DIG_W-1:0]  dig;
	logic [PROD_W-1:0] rem;

	// Multiples of the current place value.
	assign thr[0] = '0;
	for (genvar m = 1; m < 10; m++) begin : g_thr
		assign thr[m] = pos_mult(pos_q, m);
	end

	// The digit is the number of multiples that fit into the remainder.
	always_comb begin
		dig = '0;
		for (int m = 1; m < 10; m++) begin
			if ({1'b0, work_q} >= thr[m]) begin
				dig = dig + 1'b1;
			end
		end
	end

	assign rem = {1'b0, work_q} - thr[dig];

	// Leading zeros are skipped; the units digit always goes out.
	assign stat.chr      = CH_ZERO + {{(BYTE_W-DIG_W){1'b0}}, dig};
	assign stat.last_pos = (pos_q == '0);
	assign stat.emit     = (dig != '0) || started_q || stat.last_pos;

	// Position counter and leading-zero flag.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q     <= '0;
			started_q <= 1'b0;
		end else if (ctl.step && ctl.load != LD_NONE) begin
			pos_q     <= POS_W'(NUM_POS - 1);
			started_q <= 1'b0;
		end else if (ctl.step && ctl.digit) begin
			if (!stat.last_pos) begin
				pos_q <= pos_q - 1'b1;
			end
			started_q <= stat.emit;
		end
	end

	// Remainder register.
	always_ff @(posedge clk) begin
		if (ctl.step && ctl.load == LD_OP1) begin
			work_q <= sat_op(op1);
		end else if (ctl.step && ctl.load == LD_OP2) begin
			work_q <= sat_op(op2);
		end else if (ctl.step && ctl.digit) begin
			work_q <= rem[OP_W-1:0];
		end
	end

endmodule

// ===== src/acsg_sequencer.sv =====
// Microcode sequencer: step counter over the program in acsg_pkg, with a repeat on digit steps.
// Depends on acsg_pkg.
module acsg_sequencer
	import acsg_pkg::*;
(
	input  logic             clk,
	input  logic             arst_n,
	input  logic             start,
	input  logic [ACT_W-1:0] action,
	input  logic             adv,
	input  dig_stat_t        dstat,
	output uword_t           uw,
	output logic             busy
);

	logic [PC_W-1:0] pc_q;
	logic            busy_q;

	assign uw   = urom(pc_q);
	assign busy = busy_q;

	// Step counter: dispatch on a new command, repeat a digit step until the units digit.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pc_q   <= '0;
			busy_q <= 1'b0;
		end else if (start) begin
			pc_q   <= entry_of(action);
			busy_q <= 1'b1;
		end else if (adv) begin
			if (uw.last) begin
				busy_q <= 1'b0;
			end
			if (!(uw.kind == K_DIGIT && !dstat.last_pos)) begin
				pc_q <= pc_q + 1'b1;
			end
		end
	end

endmodule

// ===== src/ansi_cursor_sequence_generator_top.sv =====
// Top level of the ANSI cursor sequence generator: command capture, sequencer, digit unit
// and output register. Depends on acsg_pkg, acsg_cmd_if, acsg_byte_if and the submodules.
//
//   Channel  Dir  Payload                                   One transfer
//   cmd      in   action, first_operand, second_operand     one terminal command
//   rsp      out  out_byte, last_byte, bad_action           one byte of the sequence
//
// A command is dispatched and then runs its program steps: 2 steps for save
// and restore, 4 for clear screen, 3 + 5 for erase, back and insert, 4 + 10 for set position.
// The digit steps of the sequencer set the figure: every digit position is visited once.
// Reset clears the sequencer and the output valid flag; no clearing pass is needed.
// A stalled rsp holds the sequencer on its current step; cmd is ready only between commands.
module ansi_cursor_sequence_generator_top
	import acsg_pkg::*;
(
	input  logic         clk,
	input  logic         arst_n,
	acsg_cmd_if.sink     cmd,
	acsg_byte_if.source  rsp
);

	logic [ACT_W-1:0]  act_q;
	logic [OP_W-1:0]   op1_q;
	logic [OP_W-1:0]   op2_q;
	logic              start;
	logic              adv;
	logic              busy;
	logic              emit;
	logic [BYTE_W-1:0] byte_sel;
	logic [BYTE_W-1:0] fin_chr;
	uword_t            uw;
	dig_ctrl_t         dctl;
	dig_stat_t         dstat;
	logic              out_valid_q;
	logic [BYTE_W-1:0] out_byte_q;
	logic              last_q;
	logic              bad_q;

	assign cmd.ready = !busy;
	assign start     = cmd.valid && cmd.ready;
	// A step runs when the output register is free or being emptied.
	assign adv       = busy && (!out_valid_q || rsp.ready);

	// Command capture.
	always_ff @(posedge clk) begin
		if (start) begin
			act_q <= cmd.action;
			op1_q <= cmd.first_operand;
			op2_q <= cmd.second_operand;
		end
	end

	acsg_sequencer u_seq (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.action (cmd.action),
		.adv    (adv),
		.dstat  (dstat),
		.uw     (uw),
		.busy   (busy)
	);

	assign dctl.step  = adv;
	assign dctl.load  = uw.load;
	assign dctl.digit = (uw.kind == K_DIGIT);

	acsg_digit_unit u_dig (
		.clk    (clk),
		.arst_n (arst_n),
		.ctl    (dctl),
		.op1    (op1_q),
		.op2    (op2_q),
		.stat   (dstat)
	);

	// Final character of the single-operand CSI commands.
	always_comb begin
		case (act_q)
			ACT_BACK:   fin_chr = CH_D;
			ACT_INSERT: fin_chr = CH_AT;
			default:    fin_chr = CH_X;
		endcase
	end

	// Byte selection for the current step.
	always_comb begin
		case (uw.kind)
			K_DIGIT: begin
				byte_sel = dstat.chr;
				emit     = dstat.emit;
			end
			K_FINAL: begin
				byte_sel = fin_chr;
				emit     = 1'b1;
			end
			default: begin
				byte_sel = uw.chr;
				emit     = 1'b1;
			end
		endcase
	end

	// Output register control.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (adv && emit) begin
			out_valid_q <= 1'b1;
		end else if (rsp.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	// Output register payload.
	always_ff @(posedge clk) begin
		if (adv && emit) begin
			out_byte_q <= byte_sel;
			last_q     <= uw.last;
			bad_q      <= uw.bad;
		end
	end

	assign rsp.valid      = out_valid_q;
	assign rsp.out_byte   = out_byte_q;
	assign rsp.last_byte  = last_q;
	assign rsp.bad_action = bad_q;

endmodule

// ===== src/acsg_checker.sv =====
// Port-level checker of the ANSI cursor sequence generator and its bind to the top level.
// Depends on ansi_cursor_sequence_generator_top_macros.svh.
`include "ansi_cursor_sequence_generator_top_macros.svh"

module acsg_checker (
	input logic       clk,
	input logic       arst_n,
	input logic       in_valid,
	input logic       in_ready,
	input logic       out_valid,
	input logic       out_ready,
	input logic [7:0] out_byte,
	input logic       last_byte,
	input logic       bad_action
);

	// A command occupies the block: no second transfer right behind it.
	`ACSG_ASSERT_NEXT(a_cmd_blocks, clk, arst_n, in_valid && in_ready, !in_ready, "command not held off")

	// An error result is a single zero byte that closes the item.
	`ACSG_ASSERT_IMP(a_bad_form, clk, arst_n, out_valid && bad_action, last_byte && out_byte == 8'd0, "bad error result")

	// While a byte that is not the last one waits, the sequence is still running.
	`ACSG_ASSERT_IMP(a_mid_seq_busy, clk, arst_n, out_valid && !last_byte, !in_ready, "ready inside a sequence")

	// A stalled byte stays in place.
	`ACSG_ASSERT_NEXT(a_out_hold, clk, arst_n, out_valid && !out_ready, out_valid && $stable(out_byte) && $stable(last_byte), "stalled byte changed")

endmodule

bind ansi_cursor_sequence_generator_top acsg_checker u_acsg_checker (
	.clk        (clk),
	.arst_n     (arst_n),
	.in_valid   (cmd.valid),
	.in_ready   (cmd.ready),
	.out_valid  (rsp.valid),
	.out_ready  (rsp.ready),
	.out_byte   (rsp.out_byte),
	.last_byte  (rsp.last_byte),
	.bad_action (rsp.bad_action)
);
